@@ rtl/spq_pkg.sv @@
`timescale 1ns / 1ps

package spq_pkg;

    localparam int ID_W  = 16;
    localparam int KEY_W = 16;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_MAX    = 3'd2;
    localparam logic [2:0] CMD_SEARCH = 3'd3;
    localparam logic [2:0] CMD_ADD    = 3'd4;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_EMPTY    = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [ID_W-1:0]  entry_id;
        logic [KEY_W-1:0] key_value;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  result_id;
        logic [KEY_W-1:0] result_key;
    } t_rsp;

    typedef struct packed {
        logic [ID_W-1:0]  entry_id;
        logic [KEY_W-1:0] key;
    } t_entry;

endpackage

@@ rtl/spq_mem.sv @@
`timescale 1ns / 1ps

module spq_mem import spq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [$clog2(CAPACITY)-1:0] i_rd_addr,
    input  logic                        i_wr_en,
    input  logic [$clog2(CAPACITY)-1:0] i_wr_addr,
    input  t_entry                      i_wr_data,
    output t_entry                      o_rd_data
);

    t_entry r_mem [CAPACITY];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/spq_ctrl.sv @@
`timescale 1ns / 1ps

module spq_ctrl import spq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  t_req                        i_req,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_ready,
    output t_rsp                        o_rsp,
    output logic                        o_rd_en,
    output logic [$clog2(CAPACITY)-1:0] o_rd_addr,
    output logic                        o_wr_en,
    output logic [$clog2(CAPACITY)-1:0] o_wr_addr,
    output t_entry                      o_wr_data,
    input  t_entry                      i_rd_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int OW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // physical slot of a position counted from the head
    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] head,
                                             input logic [OW-1:0] pos);
        logic [OW:0] sum;
        sum = (OW+1)'(head) + (OW+1)'(pos);
        if (sum >= (OW+1)'(CAPACITY)) begin
            sum = sum - (OW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    logic [1:0]       r_state, n_state;
    logic [AW-1:0]    r_head, n_head;
    logic [OW-1:0]    r_occ, n_occ;
    logic             r_vld, n_vld;
    logic [OW-1:0]    r_pos, n_pos;
    logic [AW-1:0]    r_dpos, n_dpos;
    t_req             r_req, n_req;
    logic             r_placed, n_placed;
    logic             r_found, n_found;
    t_entry           r_carry, n_carry;
    logic [1:0]       r_status, n_status;
    logic [ID_W-1:0]  r_rid, n_rid;
    logic [KEY_W-1:0] r_rkey, n_rkey;

    logic [AW-1:0]    head_dec;
    logic [OW-1:0]    walk_len;
    logic [OW-1:0]    dpos_next;
    logic             last;
    logic             match;
    logic [KEY_W:0]   sum_raw;
    logic [KEY_W-1:0] sum_sat;

    assign head_dec  = (r_head == '0) ? AW'(CAPACITY - 1) : r_head - AW'(1);
    assign walk_len  = (r_req.cmd == CMD_REMOVE) ? OW'(1) : r_occ;
    assign dpos_next = OW'(r_dpos) + OW'(1);
    assign last      = (dpos_next == r_occ);
    assign match     = (i_rd_data.entry_id == r_req.entry_id);
    assign sum_raw   = (KEY_W+1)'(i_rd_data.key) + (KEY_W+1)'(r_req.key_value);
    assign sum_sat   = sum_raw[KEY_W] ? {KEY_W{1'b1}} : sum_raw[KEY_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_occ     = r_occ;
        n_vld     = 1'b0;
        n_pos     = r_pos;
        n_dpos    = r_pos[AW-1:0];
        n_req     = r_req;
        n_placed  = r_placed;
        n_found   = r_found;
        n_carry   = r_carry;
        n_status  = r_status;
        n_rid     = r_rid;
        n_rkey    = r_rkey;
        o_rd_en   = 1'b0;
        o_rd_addr = f_slot(r_head, r_pos);
        o_wr_en   = 1'b0;
        o_wr_addr = head_dec;
        o_wr_data = r_carry;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req    = i_req;
                    n_status = STAT_OK;
                    n_rid    = i_req.entry_id;
                    n_rkey   = '0;
                    n_pos    = '0;
                    n_placed = 1'b0;
                    n_found  = 1'b0;
                    n_carry  = '{entry_id: i_req.entry_id, key: i_req.key_value};
                    case (i_req.cmd) inside
                        CMD_INSERT: begin
                            if (r_occ == OW'(CAPACITY)) begin
                                n_status = STAT_FULL;
                                n_state  = S_DONE;
                            end else if (r_occ == '0) begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = head_dec;
                                o_wr_data = '{entry_id: i_req.entry_id,
                                              key: i_req.key_value};
                                n_head    = head_dec;
                                n_occ     = r_occ + OW'(1);
                                n_state   = S_DONE;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        CMD_REMOVE, CMD_MAX, CMD_SEARCH, CMD_ADD: begin
                            if (r_occ == '0) begin
                                n_status = STAT_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end

            S_WALK: begin
                // read one entry per cycle; its data comes back in the next cycle
                if (r_pos < walk_len) begin
                    o_rd_en = 1'b1;
                    n_pos   = r_pos + OW'(1);
                    n_vld   = 1'b1;
                end
                if (r_vld) begin
                    case (r_req.cmd)
                        CMD_INSERT: begin
                            if (r_dpos == '0) begin
                                if (r_req.key_value <= i_rd_data.key) begin
                                    // new head
                                    o_wr_en   = 1'b1;
                                    o_wr_addr = head_dec;
                                    o_wr_data = r_carry;
                                    n_head    = head_dec;
                                    n_occ     = r_occ + OW'(1);
                                    n_state   = S_DONE;
                                end else if (last) begin
                                    n_state = S_FLUSH;
                                end
                            end else begin
                                // once placed, every later entry moves back by one
                                if (r_placed || r_req.key_value < i_rd_data.key) begin
                                    o_wr_en   = 1'b1;
                                    o_wr_addr = f_slot(r_head, OW'(r_dpos));
                                    o_wr_data = r_carry;
                                    n_carry   = i_rd_data;
                                    n_placed  = 1'b1;
                                end
                                if (last) begin
                                    n_state = S_FLUSH;
                                end
                            end
                        end
                        CMD_REMOVE: begin
                            n_rid   = i_rd_data.entry_id;
                            n_rkey  = i_rd_data.key;
                            n_head  = f_slot(r_head, OW'(1));
                            n_occ   = r_occ - OW'(1);
                            n_state = S_DONE;
                        end
                        CMD_MAX: begin
                            if (r_dpos == '0 || r_rkey <= i_rd_data.key) begin
                                n_rid  = i_rd_data.entry_id;
                                n_rkey = i_rd_data.key;
                            end
                            if (last) begin
                                n_state = S_DONE;
                            end
                        end
                        CMD_SEARCH: begin
                            if (match) begin
                                n_found = 1'b1;
                                n_rkey  = i_rd_data.key;
                            end
                            if (last) begin
                                n_status = (r_found || match) ? STAT_OK : STAT_NOTFOUND;
                                n_state  = S_DONE;
                            end
                        end
                        CMD_ADD: begin
                            if (match) begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = f_slot(r_head, OW'(r_dpos));
                                o_wr_data = '{entry_id: r_req.entry_id, key: sum_sat};
                                n_found   = 1'b1;
                                n_rkey    = sum_sat;
                            end
                            if (last) begin
                                n_status = (r_found || match) ? STAT_OK : STAT_NOTFOUND;
                                n_state  = S_DONE;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end

            S_FLUSH: begin
                // last displaced entry (or the new one) lands at the tail
                o_wr_en   = 1'b1;
                o_wr_addr = f_slot(r_head, r_occ);
                o_wr_data = r_carry;
                n_occ     = r_occ + OW'(1);
                n_state   = S_DONE;
            end

            S_DONE: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_occ   <= '0;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_occ   <= n_occ;
            r_vld   <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_dpos   <= n_dpos;
        r_req    <= n_req;
        r_placed <= n_placed;
        r_found  <= n_found;
        r_carry  <= n_carry;
        r_status <= n_status;
        r_rid    <= n_rid;
        r_rkey   <= n_rkey;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_DONE);
    assign o_rsp       = '{status: r_status, result_id: r_rid, result_key: r_rkey};

endmodule

@@ rtl/sorted_priority_queue_table.sv @@
// channel   dir  handshake                     payload
// request   in   i_req_valid / o_req_ready     i_req (t_req)
// response  out  o_rsp_valid / i_rsp_ready     o_rsp (t_rsp)
//
// One request at a time, walked one entry per cycle through the single memory read port.
// The response register loads when the controller is done: remove reads the head only; find
// max, search and add walk every entry; insert stops at the head entry if it goes in front,
// else walks to the end and then writes the tail; an empty or full table, an insert into an
// empty table and an unused code need no walk. Reset empties the table; the memory has no
// clearing pass. A waiting response blocks new requests only once another one is done too.
`timescale 1ns / 1ps

module sorted_priority_queue_table import spq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int AW = $clog2(CAPACITY);

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    t_entry        rd_data;

    logic          core_valid;
    logic          core_ready;
    t_rsp          core_rsp;

    logic          r_out_valid;
    t_rsp          r_out;

    spq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (core_valid),
        .i_rsp_ready (core_ready),
        .o_rsp       (core_rsp),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .i_rd_data   (rd_data)
    );

    spq_mem #(
        .CAPACITY (CAPACITY)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    assign core_ready = !r_out_valid || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_ready) begin
            r_out_valid <= core_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_ready && core_valid) begin
            r_out <= core_rsp;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

@@ rtl/spq_chk.sv @@
`timescale 1ns / 1ps

module spq_chk import spq_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_ready,
    input logic o_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp o_rsp
);

    // only one request in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken while another is in flight");

    // a new response comes only from a finished request, whose busy state blocks requests
    a_rsp_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(!o_req_ready))
        else $error("response without a busy cycle before it");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled response dropped or changed");

endmodule

bind sorted_priority_queue_table spq_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);

@@ verif/tb_sorted_priority_queue_table.sv @@
`timescale 1ns / 1ps

module tb_sorted_priority_queue_table;
    import spq_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 1380;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 400000;

    // codes the block does not decode
    localparam logic [2:0] CMD_SPARE5 = 3'd5;
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX, MODE_NOISE} t_mode;

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    t_req req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    t_rsp rsp;

    t_req   pending_q[$];
    t_rsp   expected_q[$];
    t_entry entries_q[$];

    logic [ID_W-1:0] id_pool[8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                    16'h1234, 16'h00FF, 16'hFF00, 16'h5A5A};

    int cycle_cnt    = 0;
    int mismatch_cnt = 0;
    int checked_cnt  = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    int stall_mode   = 0;
    int sat_cnt      = 0;
    int peak_occ     = 0;
    int cmd_cnt[8];
    int status_cnt[4];
    logic [31:0] stall_word = '0;

    sorted_priority_queue_table #(.CAPACITY(CAPACITY)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Table kept in logical order, head first.
    function automatic t_rsp predict_table(t_req r);
        t_rsp           o;
        t_entry         e;
        int             pos;
        logic [KEY_W:0] sum;
        bit             found;
        o.status     = STAT_OK;
        o.result_id  = r.entry_id;
        o.result_key = '0;
        found        = 1'b0;
        case (r.cmd)
            CMD_INSERT: begin
                if (entries_q.size() >= CAPACITY) begin
                    o.status = STAT_FULL;
                end else begin
                    e.entry_id = r.entry_id;
                    e.key      = r.key_value;
                    if (entries_q.size() == 0 || r.key_value <= entries_q[0].key) begin
                        entries_q.push_front(e);
                    end else begin
                        pos = 1;
                        while (pos < entries_q.size() && entries_q[pos].key <= r.key_value)
                            pos++;
                        entries_q.insert(pos, e);
                    end
                end
            end
            CMD_REMOVE: begin
                if (entries_q.size() == 0) begin
                    o.status = STAT_EMPTY;
                end else begin
                    e            = entries_q.pop_front();
                    o.result_id  = e.entry_id;
                    o.result_key = e.key;
                end
            end
            CMD_MAX: begin
                if (entries_q.size() == 0) begin
                    o.status = STAT_EMPTY;
                end else begin
                    o.result_id  = entries_q[0].entry_id;
                    o.result_key = entries_q[0].key;
                    // ties go to the later entry
                    foreach (entries_q[i]) begin
                        if (o.result_key <= entries_q[i].key) begin
                            o.result_id  = entries_q[i].entry_id;
                            o.result_key = entries_q[i].key;
                        end
                    end
                end
            end
            CMD_SEARCH: begin
                if (entries_q.size() == 0) begin
                    o.status = STAT_EMPTY;
                end else begin
                    foreach (entries_q[i]) begin
                        if (entries_q[i].entry_id == r.entry_id) begin
                            found        = 1'b1;
                            o.result_key = entries_q[i].key;
                        end
                    end
                    if (!found) o.status = STAT_NOTFOUND;
                end
            end
            CMD_ADD: begin
                if (entries_q.size() == 0) begin
                    o.status = STAT_EMPTY;
                end else begin
                    foreach (entries_q[i]) begin
                        if (entries_q[i].entry_id == r.entry_id) begin
                            sum = {1'b0, entries_q[i].key} + {1'b0, r.key_value};
                            if (sum[KEY_W]) begin
                                sum = {1'b0, {KEY_W{1'b1}}};
                                sat_cnt++;
                            end
                            entries_q[i].key = sum[KEY_W-1:0];
                            found            = 1'b1;
                            o.result_key     = sum[KEY_W-1:0];
                        end
                    end
                    if (!found) o.status = STAT_NOTFOUND;
                end
            end
            default: ;
        endcase
        cmd_cnt[r.cmd]++;
        status_cnt[o.status]++;
        if (entries_q.size() > peak_occ) peak_occ = entries_q.size();
        return o;
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 4) == 0) return ID_W'($urandom_range(0, 16'hFFFF));
        return id_pool[$urandom_range(0, 7)];
    endfunction

    // small, mid-scale and top-end keys make ties and saturation likely
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 4))
            0:       return KEY_W'($urandom_range(0, 7));
            1:       return KEY_W'($urandom_range(16'hFFF8, 16'hFFFF));
            2:       return KEY_W'($urandom_range(16'h7FFE, 16'h8001));
            default: return KEY_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic t_req make_request(t_mode mode);
        t_req r;
        int   pick;
        pick        = $urandom_range(0, 99);
        r.entry_id  = pick_id();
        r.key_value = pick_key();
        case (mode)
            MODE_FILL:
                r.cmd = pick < 60 ? CMD_INSERT : pick < 70 ? CMD_REMOVE :
                        pick < 80 ? CMD_MAX : pick < 90 ? CMD_SEARCH : CMD_ADD;
            MODE_DRAIN:
                r.cmd = pick < 50 ? CMD_REMOVE : pick < 65 ? CMD_INSERT :
                        pick < 75 ? CMD_MAX : pick < 88 ? CMD_SEARCH : CMD_ADD;
            MODE_MIX:
                r.cmd = pick < 30 ? CMD_INSERT : pick < 50 ? CMD_REMOVE :
                        pick < 65 ? CMD_MAX : pick < 82 ? CMD_SEARCH : CMD_ADD;
            default: begin
                r.cmd       = 3'($urandom_range(0, 7));
                r.entry_id  = ID_W'($urandom_range(0, 16'hFFFF));
                r.key_value = KEY_W'($urandom_range(0, 16'hFFFF));
            end
        endcase
        if (mode != MODE_NOISE && r.cmd == CMD_ADD && $urandom_range(0, 1) == 0)
            r.key_value = KEY_W'($urandom_range(0, 63));
        return r;
    endfunction

    task automatic push_req(logic [2:0] cmd, logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
        t_req r;
        r.cmd       = cmd;
        r.entry_id  = id;
        r.key_value = key;
        pending_q.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || req_valid || expected_q.size() != 0)
            @(negedge i_clk);
    endtask

    // Driver: bursts of requests with random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_valid <= 1'b0;
            req       <= '0;
        end else begin
            if (req_valid && req_ready)
                expected_q.push_back(predict_table(req));
            if (!req_valid || req_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    req       <= pending_q.pop_front();
                    req_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks responses in order and drives the stall pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            if (rsp_valid && rsp_ready) begin
                if (expected_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("ERROR cycle %0d: unexpected response st=%0d id=%h key=%h",
                                 cycle_cnt, rsp.status, rsp.result_id, rsp.result_key);
                end else begin
                    t_rsp exp;
                    exp = expected_q.pop_front();
                    checked_cnt++;
                    if (rsp.status !== exp.status || rsp.result_id !== exp.result_id ||
                        rsp.result_key !== exp.result_key) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("ERROR cycle %0d: expected %0d/%h/%h, got %0d/%h/%h",
                                     cycle_cnt, exp.status, exp.result_id, exp.result_key,
                                     rsp.status, rsp.result_id, rsp.result_key);
                    end
                end
            end
            if (cycle_cnt % 128 == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_word = $urandom;
            end
            case (stall_mode)
                0:       rsp_ready <= 1'b1;
                1:       rsp_ready <= stall_word[cycle_cnt % 32];
                2:       rsp_ready <= ($urandom_range(0, 3) != 0);
                default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_cnt, expected_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int    queued;
        int    seg;
        int    len;
        int    pick;
        t_mode mode;
        t_req  r;
        queued = 0;
        seg    = 0;
        foreach (cmd_cnt[i]) cmd_cnt[i] = 0;
        foreach (status_cnt[i]) status_cnt[i] = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty table, spare codes, ordering, ties, saturation
        push_req(CMD_REMOVE, 16'hFFFF, 16'hFFFF);
        push_req(CMD_MAX,    16'h0000, 16'h0000);
        push_req(CMD_SEARCH, 16'h0001, 16'h0000);
        push_req(CMD_ADD,    16'h0001, 16'h0001);
        push_req(CMD_SPARE7, 16'hFFFF, 16'hFFFF);
        push_req(CMD_INSERT, 16'h0001, 16'h8000);
        push_req(CMD_INSERT, 16'h0002, 16'h0000);
        push_req(CMD_INSERT, 16'hFFFF, 16'hFFFF);
        push_req(CMD_INSERT, 16'h0003, 16'h8000);
        push_req(CMD_INSERT, 16'h0001, 16'h0000);
        push_req(CMD_SEARCH, 16'h0001, 16'h0000);
        push_req(CMD_SEARCH, 16'h7777, 16'h0000);
        push_req(CMD_ADD,    16'h7777, 16'h0010);
        push_req(CMD_ADD,    16'h0001, 16'hFFFF);
        push_req(CMD_MAX,    16'h0000, 16'h0000);
        push_req(CMD_SPARE5, 16'h0000, 16'h0000);
        push_req(CMD_SPARE6, 16'h5555, 16'hAAAA);
        push_req(CMD_REMOVE, 16'h0000, 16'h0000);
        push_req(CMD_ADD,    16'h0002, 16'h0005);
        push_req(CMD_MAX,    16'h0000, 16'h0000);
        push_req(CMD_REMOVE, 16'h0000, 16'h0000);
        wait_drained();

        // fill past capacity first, then random segments
        for (int i = 0; i < CAPACITY + 4; i++)
            push_req(CMD_INSERT, pick_id(), pick_key());
        queued += CAPACITY + 4;
        while (queued < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            mode = pick < 30 ? MODE_FILL : pick < 55 ? MODE_DRAIN :
                   pick < 90 ? MODE_MIX : MODE_NOISE;
            len  = $urandom_range(10, 60);
            repeat (len) begin
                r = make_request(mode);
                pending_q.push_back(r);
                if (r.cmd <= CMD_ADD) queued++;
            end
            seg++;
            if (seg % 7 == 0) wait_drained();
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("summary: %0d responses checked; insert %0d, remove %0d, max %0d,",
                 checked_cnt, cmd_cnt[CMD_INSERT], cmd_cnt[CMD_REMOVE], cmd_cnt[CMD_MAX]);
        $display("summary: search %0d, add %0d; ok %0d, empty %0d, not found %0d, full %0d,",
                 cmd_cnt[CMD_SEARCH], cmd_cnt[CMD_ADD], status_cnt[STAT_OK],
                 status_cnt[STAT_EMPTY], status_cnt[STAT_NOTFOUND], status_cnt[STAT_FULL]);
        $display("summary: saturated adds %0d, peak occupancy %0d", sat_cnt, peak_occ);
        if (mismatch_cnt == 0 && expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
